### sv/nabp_pkg.sv
// Shared widths, constants, codes and helpers of the neighbor-aware block packer.
`default_nettype none
package nabp_pkg;

	localparam int NODE_ID_W     = 20;
	localparam int DEGREE_W      = 8;
	localparam int BLOCK_IDX_W   = 21;
	localparam int BYTES_W       = 17;
	localparam int KB_W          = 7;
	localparam int DIMS_W        = 11;
	localparam int NEED_W        = 14;
	localparam int SUM_W         = 12;
	localparam int KB_SHIFT      = 10;
	localparam int WORD_SHIFT    = 2;
	localparam int BLOCK_RESERVE = 8;
	localparam int HEADER_WORDS  = 2;

	localparam int ROW_BITS = 64;
	localparam int BIT_W    = 6;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	localparam int DEF_NODE_CAPACITY = 1048576;
	localparam int DEF_MAX_DEGREE    = 255;
	localparam int DEF_BLOCK_KB      = 4;
	localparam int DEF_VECTOR_DIMS   = 128;

	typedef enum logic {
		REG_BLOCK_KB    = 1'b0,
		REG_VECTOR_DIMS = 1'b1
	} reg_idx_t;

	typedef enum logic {
		REQ_HEAD     = 1'b0,
		REQ_NEIGHBOR = 1'b1
	} req_kind_t;

	function automatic int map_rows(int cap);
		return (cap + ROW_BITS - 1) / ROW_BITS;
	endfunction

	function automatic int map_aw(int cap);
		int rows;
		rows = map_rows(cap);
		return (rows > 1) ? $clog2(rows) : 1;
	endfunction

	// nominal block size in bytes; a zero kb setting counts as one
	function automatic logic [BYTES_W-1:0] nominal_bytes(logic [KB_W-1:0] kb);
		logic [KB_W-1:0] kb_eff;
		kb_eff = (kb == '0) ? KB_W'(1) : kb;
		return BYTES_W'(kb_eff) << KB_SHIFT;
	endfunction

endpackage
`default_nettype wire

### sv/nabp_in_if.sv
// Item channel interface: node heads and neighbor items.
`default_nettype none
interface nabp_in_if import nabp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [NODE_ID_W-1:0] node_id;
	logic [DEGREE_W-1:0]  degree;

	modport source (output valid, req_type, node_id, degree, input ready);
	modport sink   (input valid, req_type, node_id, degree, output ready);
endinterface
`default_nettype wire

### sv/nabp_out_if.sv
// Result channel interface: one placement per transaction.
`default_nettype none
interface nabp_out_if import nabp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [NODE_ID_W-1:0]   placed_node;
	logic [BLOCK_IDX_W-1:0] block_index;
	logic                   opened_block;
	logic [BYTES_W-1:0]     block_bytes;
	logic [BYTES_W-1:0]     bytes_left;

	modport source (output valid, placed_node, block_index, opened_block, block_bytes,
		bytes_left, input ready);
	modport sink   (input valid, placed_node, block_index, opened_block, block_bytes,
		bytes_left, output ready);
endinterface
`default_nettype wire

### sv/nabp_bitmap.sv
// Placed-node bitmap: 64-bit rows in one RAM, cleared by a sweep after reset.
`default_nettype none
module nabp_bitmap import nabp_pkg::*; #(
	parameter int NODE_CAPACITY = DEF_NODE_CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              rd_en,
	input  wire logic [map_aw(NODE_CAPACITY)-1:0]  rd_row,
	output      logic [ROW_BITS-1:0]               rd_data,
	input  wire logic                              wr_en,
	input  wire logic [map_aw(NODE_CAPACITY)-1:0]  wr_row,
	input  wire logic [ROW_BITS-1:0]               wr_data,
	output      logic                              ready
);
	localparam int ROWS   = map_rows(NODE_CAPACITY);
	localparam int ROW_AW = map_aw(NODE_CAPACITY);

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_data_q;
	logic [ROW_AW-1:0]   clr_q;
	logic                clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == ROW_AW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + ROW_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = !clearing_q;
endmodule
`default_nettype wire

### sv/neighbor_aware_block_packer_core.sv
// Top level of the neighbor-aware block packer: control, block bookkeeping, APB registers.
//
// Channel  Dir  Transaction
// item     in   node head or neighbor: req_type, node_id, degree
// result   out  placement: placed_node, block_index, opened_block, block_bytes, bytes_left
// apb      in   register writes/reads: block_kb @0x0, vector_dims @0x4
//
// For an item, the accept edge reads its bitmap row and the decide state then
// decides and writes the row back. A head that opens a block first runs the
// block size search (one add per cycle) until the candidate exceeds the record,
// and then decides once more.
// After reset the bitmap sweep clears map_rows(NODE_CAPACITY) rows (16384 by
// default) with item.ready low; register writes are taken during the sweep.
// A full result register stalls only the item that wants to place a node.
`default_nettype none
module neighbor_aware_block_packer_core import nabp_pkg::*; #(
	parameter int NODE_CAPACITY = DEF_NODE_CAPACITY,
	parameter int MAX_DEGREE    = DEF_MAX_DEGREE
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	nabp_in_if.sink                    item,
	nabp_out_if.source                 result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready
);
	localparam int ROW_AW   = map_aw(NODE_CAPACITY);
	localparam int ID_EXT_W = ROW_AW + BIT_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DECIDE = 3'b010,
		ST_GROW   = 3'b100
	} state_t;

	state_t state_q;

	// configuration
	logic [KB_W-1:0]   kb_q;
	logic [DIMS_W-1:0] dims_q;
	logic              cfg_wr;
	reg_idx_t          cfg_sel;
	logic [BYTES_W-1:0] nb_wr;

	// block bookkeeping
	logic [BYTES_W-1:0]     block_q;
	logic [BYTES_W-1:0]     free_q;
	logic [BLOCK_IDX_W-1:0] idx_q;
	logic                   scan_q;
	logic                   fresh_q;
	logic                   opened_q;   // block opened for the head in flight
	logic [BYTES_W-1:0]     grow_q;     // candidate size in the search loop
	logic [BYTES_W-1:0]     nb;

	// item held over the decide cycle
	logic                 kind_s1;
	logic [NODE_ID_W-1:0] id_s1;
	logic [NEED_W-1:0]    need_s1;
	logic                 id_ok_s1;
	logic [BIT_W-1:0]     bit_s1;

	// accept side
	logic                 accept;
	logic                 id_ok_in;
	logic [DEGREE_W-1:0]  deg_sat;
	logic [SUM_W-1:0]     words;
	logic [ID_EXT_W-1:0]  id_ext;

	// bitmap
	logic                map_ready;
	logic [ROW_BITS-1:0] map_rd;
	logic [ID_EXT_W-1:0] id_ext_s1;
	logic [ROW_AW-1:0]   row_s1;

	// decide
	logic               placed;
	logic [BYTES_W-1:0] need17;
	logic               need_gt_free;
	logic               out_free;
	logic               emit;
	logic               done;
	logic               to_grow;
	logic               scan_clr;
	logic [BYTES_W-1:0] new_free;

	// result register
	logic                   out_valid_q;
	logic [NODE_ID_W-1:0]   rs_node_q;
	logic [BLOCK_IDX_W-1:0] rs_idx_q;
	logic                   rs_open_q;
	logic [BYTES_W-1:0]     rs_bytes_q;
	logic [BYTES_W-1:0]     rs_left_q;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign cfg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign nb_wr   = nominal_bytes(pwdata[KB_W-1:0]);

	always_comb begin
		case (cfg_sel)
			REG_BLOCK_KB:    prdata = APB_DATA_W'(kb_q);
			REG_VECTOR_DIMS: prdata = APB_DATA_W'(dims_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- accept ----------------
	assign item.ready = (state_q == ST_IDLE) && map_ready;
	assign accept     = item.valid && item.ready;
	assign id_ok_in   = 32'(item.node_id) < NODE_CAPACITY;
	assign deg_sat    = (32'(item.degree) > MAX_DEGREE) ? DEGREE_W'(MAX_DEGREE) : item.degree;
	assign words      = SUM_W'(dims_q) + SUM_W'(deg_sat) + SUM_W'(HEADER_WORDS);
	assign id_ext     = ID_EXT_W'(item.node_id);
	assign id_ext_s1  = ID_EXT_W'(id_s1);
	assign row_s1     = id_ext_s1[ID_EXT_W-1:BIT_W];

	nabp_bitmap #(
		.NODE_CAPACITY(NODE_CAPACITY)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept && id_ok_in),
		.rd_row (id_ext[ID_EXT_W-1:BIT_W]),
		.rd_data(map_rd),
		.wr_en  (emit),
		.wr_row (row_s1),
		.wr_data(map_rd | (ROW_BITS'(1) << bit_s1)),
		.ready  (map_ready)
	);

	// ---------------- decide ----------------
	assign nb           = nominal_bytes(kb_q);
	assign placed       = map_rd[bit_s1];
	assign need17       = BYTES_W'(need_s1);
	assign need_gt_free = need17 > free_q;
	assign out_free     = !out_valid_q || result.ready;

	always_comb begin
		emit     = 1'b0;
		done     = 1'b0;
		to_grow  = 1'b0;
		scan_clr = 1'b0;
		new_free = free_q;
		if (state_q == ST_DECIDE) begin
			if (!id_ok_s1) begin
				done     = 1'b1;
				scan_clr = (kind_s1 == REQ_HEAD);
			end else if (kind_s1 == REQ_HEAD) begin
				if (placed) begin
					done     = 1'b1;
					scan_clr = 1'b1;
				end else if (!opened_q && need_gt_free) begin
					to_grow = 1'b1;
				end else if (out_free) begin
					// a fresh block may still be short by up to the reserve
					emit     = 1'b1;
					done     = 1'b1;
					new_free = need_gt_free ? '0 : free_q - need17;
				end
			end else begin
				if (!scan_q || placed) begin
					done = 1'b1;
				end else if (need_gt_free) begin
					done     = 1'b1;
					scan_clr = 1'b1;
				end else if (out_free) begin
					emit     = 1'b1;
					done     = 1'b1;
					new_free = free_q - need17;
				end
			end
		end
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kb_q        <= KB_W'(DEF_BLOCK_KB);
			dims_q      <= DIMS_W'(DEF_VECTOR_DIMS);
			block_q     <= BYTES_W'(DEF_BLOCK_KB) << KB_SHIFT;
			free_q      <= (BYTES_W'(DEF_BLOCK_KB) << KB_SHIFT) - BYTES_W'(BLOCK_RESERVE);
			idx_q       <= '0;
			scan_q      <= 1'b0;
			fresh_q     <= 1'b1;
			opened_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_sel)
					REG_BLOCK_KB: begin
						kb_q <= pwdata[KB_W-1:0];
						// before the first item the initial block follows the setting
						if (fresh_q) begin
							block_q <= nb_wr;
							free_q  <= nb_wr - BYTES_W'(BLOCK_RESERVE);
						end
					end
					REG_VECTOR_DIMS: dims_q <= pwdata[DIMS_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				fresh_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (to_grow) begin
						state_q <= ST_GROW;
					end else if (done) begin
						state_q <= ST_IDLE;
					end
					if (emit) begin
						free_q   <= new_free;
						opened_q <= 1'b0;
						if (kind_s1 == REQ_HEAD) begin
							scan_q <= 1'b1;
						end
					end
					if (scan_clr) begin
						scan_q <= 1'b0;
					end
				end
				ST_GROW: begin
					// smallest multiple of the nominal size above the record
					if (grow_q > need17) begin
						block_q  <= grow_q;
						free_q   <= grow_q - BYTES_W'(BLOCK_RESERVE);
						idx_q    <= idx_q + BLOCK_IDX_W'(1);
						opened_q <= 1'b1;
						state_q  <= ST_DECIDE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= item.req_type;
			id_s1    <= item.node_id;
			need_s1  <= NEED_W'(words) << WORD_SHIFT;
			id_ok_s1 <= id_ok_in;
			bit_s1   <= id_ext[BIT_W-1:0];
		end
		if (to_grow) begin
			grow_q <= nb;
		end else if (state_q == ST_GROW && grow_q <= need17) begin
			grow_q <= grow_q + nb;
		end
		if (emit) begin
			rs_node_q  <= id_s1;
			rs_idx_q   <= idx_q;
			rs_open_q  <= opened_q;
			rs_bytes_q <= block_q;
			rs_left_q  <= new_free;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.placed_node  = rs_node_q;
	assign result.block_index  = rs_idx_q;
	assign result.opened_block = rs_open_q;
	assign result.block_bytes  = rs_bytes_q;
	assign result.bytes_left   = rs_left_q;

`ifndef SYNTHESIS
	// a new result only ever comes out of the decide cycle
	a_emit_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_DECIDE))
		else $error("result appeared outside the decide cycle");

	// every block keeps its reserve
	a_reserve_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, rs_left_q} + 18'(BLOCK_RESERVE) <= {1'b0, rs_bytes_q}))
		else $error("bytes left eat into the block reserve");

	// a bitmap write comes only in the decide state, for a valid item in flight
	a_write_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (id_ok_s1 && state_q == ST_DECIDE && !item.ready))
		else $error("bitmap written without a valid item in flight");

	// the size search never overshoots the record by more than one nominal block
	a_grow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GROW) |-> ({1'b0, grow_q} <= {1'b0, need17} + {1'b0, nb}))
		else $error("block size search ran past its bound");
`endif
endmodule
`default_nettype wire
